// ===== rtl/receive_window_tracker_assert.svh =====
// ---------------------------------------------------------------------------
// Receive window tracker assertion macros
// Concurrent assertion wrappers. They are compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef RECEIVE_WINDOW_TRACKER_ASSERT_SVH
`define RECEIVE_WINDOW_TRACKER_ASSERT_SVH

`ifndef SYNTH
// This assertion is checked on every clock edge except while reset is high.
`define RWT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// This assertion is checked on every clock edge, during reset as well.
`define RWT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RWT_ASSERT(label, clk, rst, prop, msg)
`define RWT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/rwt_pkg.sv =====
// ---------------------------------------------------------------------------
// Receive window tracker package
// Sizes, codes and shared types for the receive window tracker.
// ---------------------------------------------------------------------------
package rwt_pkg;

   // Window geometry.
   localparam int WINDOW   = 64;
   localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int ADV_W    = 7;
   localparam int INDEX_W  = 64;
   localparam int MASK_W   = 64;
   localparam int WS_W     = 7;
   localparam int STATUS_W = 2;
   localparam int RSP_W    = 144;

   // Reset value of the window size register.
   localparam logic [WS_W-1:0] WS_RESET = WS_W'(64);
   localparam logic [WS_W-1:0] WS_MAX   = WS_W'(MASK_W);

   // Outcome of a mark.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_NEW     = 2'd0,
      STATUS_SETTLED = 2'd1,
      STATUS_BEYOND  = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_SLIDE,
      ST_DONE
   } state_type;

   // Control shared by every flag cell.
   typedef struct packed {
      logic shift;
      logic mark;
   } cell_ctrl_type;

endpackage

// ===== rtl/rwt_cell.sv =====
// ---------------------------------------------------------------------------
// Receive window flag cell
// Holds the consumed flag of one window position and hands it down the row.
// ---------------------------------------------------------------------------
module rwt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rwt_pkg::cell_ctrl_type ctrl,
   input  logic                  mark_hit,
   input  logic                  upper_flag,
   output logic                  flag
);

   logic flag_ff;
   logic flag_in;

   // A slide takes the neighbour's flag; a mark sets this flag when it is the target.
   always_comb begin
      if (ctrl.shift) begin
         flag_in = upper_flag;
      end else if (ctrl.mark && mark_hit) begin
         flag_in = 1'b1;
      end else begin
         flag_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign flag = flag_ff;

endmodule

// ===== rtl/receive_window_tracker.sv =====
// ---------------------------------------------------------------------------
// Receive window tracker
// Marks message indexes as consumed and slides a 64-bit base past them.
// ---------------------------------------------------------------------------
// Each item is accepted, classified and marked, then the base slides past every
// leading consumed flag (A slides, where A, 0 to 64, is the advance count it
// reports), then the result is loaded; only then can the next item be accepted.
// The slide dominates: the consumed flags live in a row of cells that shifts
// by one position per cycle. A result waiting in the output register does not
// block the next item from being accepted; the following result waits for it.
module receive_window_tracker (
   input  logic                              clock,
   input  logic                              reset,
   // Input item: message_index [63:0].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rwt_pkg::INDEX_W-1:0]       req_tdata,
   // Result item: base_index [63:0], advance_count [70:64],
   // pending_mask [134:71], mark_status [136:135], zero fill [143:137].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rwt_pkg::RSP_W-1:0]         rsp_tdata,
   // Window size register.
   input  logic                              csr_we,
   input  logic [rwt_pkg::WS_W-1:0]          csr_wdata
);

`include "receive_window_tracker_assert.svh"

   rwt_pkg::state_type                state_ff, state_in;
   logic [rwt_pkg::INDEX_W-1:0]       idx_ff, idx_in;
   logic [rwt_pkg::INDEX_W-1:0]       base_ff, base_in;
   logic [rwt_pkg::ADV_W-1:0]         adv_ff, adv_in;
   rwt_pkg::status_type               status_ff, status_in;
   logic [rwt_pkg::WS_W-1:0]          ws_ff, ws_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rwt_pkg::RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   logic [rwt_pkg::WINDOW-1:0]        flags;
   logic [rwt_pkg::WINDOW:0]          chain;
   rwt_pkg::cell_ctrl_type            cell_ctrl;

   logic [rwt_pkg::INDEX_W-1:0]       offset;
   logic                              below_base;
   logic                              beyond_window;
   logic [rwt_pkg::IDX_W-1:0]         hit_idx;
   logic                              already_set;
   logic                              can_slide;
   logic                              out_free;
   logic                              accept;
   logic                              load_rsp;
   logic [rwt_pkg::WS_W-1:0]          ws_clamped;
   logic [rwt_pkg::MASK_W:0]          span;
   logic [rwt_pkg::MASK_W-1:0]        pending;

   // Handshake conditions.
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Classify the stored index against the window.
   always_comb begin
      offset        = idx_ff - base_ff;
      below_base    = offset[rwt_pkg::INDEX_W-1];
      beyond_window = !below_base &&
                      (offset[rwt_pkg::INDEX_W-2:0] >= (rwt_pkg::INDEX_W-1)'(rwt_pkg::WINDOW));
      hit_idx       = offset[rwt_pkg::IDX_W-1:0];
      already_set   = flags[hit_idx];
   end

   assign can_slide = flags[0] && (adv_ff < rwt_pkg::ADV_W'(rwt_pkg::WINDOW));

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rwt_pkg::ST_IDLE: begin
            if (accept) state_in = rwt_pkg::ST_MARK;
         end
         rwt_pkg::ST_MARK: begin
            state_in = rwt_pkg::ST_SLIDE;
         end
         rwt_pkg::ST_SLIDE: begin
            if (!can_slide) state_in = rwt_pkg::ST_DONE;
         end
         rwt_pkg::ST_DONE: begin
            if (out_free) state_in = rwt_pkg::ST_IDLE;
         end
         default: begin
            state_in = rwt_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready      = 1'b0;
      cell_ctrl.shift = 1'b0;
      cell_ctrl.mark  = 1'b0;
      load_rsp        = 1'b0;
      case (state_ff)
         rwt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         rwt_pkg::ST_MARK: begin
            cell_ctrl.mark = !below_base && !beyond_window && !already_set;
         end
         rwt_pkg::ST_SLIDE: begin
            cell_ctrl.shift = can_slide;
         end
         rwt_pkg::ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Row of flag cells; each slide moves every flag one place towards the base.
   assign chain[rwt_pkg::WINDOW] = 1'b0;
   for (genvar i = 0; i < rwt_pkg::WINDOW; i++) begin : g_cell
      rwt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .mark_hit   (hit_idx == rwt_pkg::IDX_W'(i)),
         .upper_flag (chain[i+1]),
         .flag       (chain[i])
      );
   end
   assign flags = chain[rwt_pkg::WINDOW-1:0];

   // Pending mask over the configured window.
   always_comb begin
      ws_clamped = (ws_ff > rwt_pkg::WS_MAX) ? rwt_pkg::WS_MAX : ws_ff;
      span       = ((rwt_pkg::MASK_W+1)'(1) << ws_clamped) - (rwt_pkg::MASK_W+1)'(1);
      pending    = span[rwt_pkg::MASK_W-1:0] & ~rwt_pkg::MASK_W'(flags);
   end

   // Datapath registers.
   always_comb begin
      idx_in       = accept ? req_tdata : idx_ff;
      base_in      = base_ff;
      adv_in       = adv_ff;
      status_in    = status_ff;
      ws_in        = csr_we ? csr_wdata : ws_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == rwt_pkg::ST_MARK) begin
         adv_in = '0;
         // An index below the base wins over a dropped one, which wins over a repeat.
         if (below_base) begin
            status_in = rwt_pkg::STATUS_SETTLED;
         end else if (beyond_window) begin
            status_in = rwt_pkg::STATUS_BEYOND;
         end else if (already_set) begin
            status_in = rwt_pkg::STATUS_SETTLED;
         end else begin
            status_in = rwt_pkg::STATUS_NEW;
         end
      end
      if (cell_ctrl.shift) begin
         base_in = base_ff + rwt_pkg::INDEX_W'(1);
         adv_in  = adv_ff + rwt_pkg::ADV_W'(1);
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(rwt_pkg::RSP_W-137)'(0), status_ff, pending, adv_ff, base_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rwt_pkg::ST_IDLE;
         base_ff      <= '0;
         adv_ff       <= '0;
         ws_ff        <= rwt_pkg::WS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         adv_ff       <= adv_in;
         ws_ff        <= ws_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the sequencer and the cell row.
   `RWT_ASSERT(a_adv_bounded, clock, reset, adv_ff <= rwt_pkg::ADV_W'(rwt_pkg::WINDOW), "advance count beyond window")
   `RWT_ASSERT(a_slide_moves_base, clock, reset, cell_ctrl.shift |=> base_ff == $past(base_ff) + rwt_pkg::INDEX_W'(1), "base did not follow a slide")
   `RWT_ASSERT(a_no_mark_when_dropped, clock, reset, (state_ff == rwt_pkg::ST_MARK && (below_base || beyond_window)) |=> $stable(flags), "flags changed on a dropped mark")
   `RWT_ASSERT(a_done_loads_result, clock, reset, (state_ff == rwt_pkg::ST_DONE && out_free) |=> rsp_valid_ff, "result not presented after slide")
   `RWT_ASSERT_ALWAYS(a_base_flag_clear_idle, clock, (!reset && state_ff == rwt_pkg::ST_IDLE) |-> !flags[0], "leading flag left set after slide")

endmodule

// ===== sim/tb_receive_window_tracker.sv =====
// ---------------------------------------------------------------------------
// Receive window tracker testbench
// Streams message indexes into the tracker and checks every result item
// against a predictor of the window state. A short directed part covers the
// edges of the window; window-filling runs with shuffled order and noise
// follow, over several window size settings.
// ---------------------------------------------------------------------------
module tb_receive_window_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILL_W = rwt_pkg::RSP_W - rwt_pkg::INDEX_W - rwt_pkg::ADV_W -
                           rwt_pkg::MASK_W - rwt_pkg::STATUS_W;

   // Result item as it appears on rsp_tdata, lowest field last.
   typedef struct packed {
      logic [FILL_W-1:0]                  fill;
      rwt_pkg::status_type                mark_status;
      logic [rwt_pkg::MASK_W-1:0]         pending_mask;
      logic [rwt_pkg::ADV_W-1:0]          advance_count;
      logic [rwt_pkg::INDEX_W-1:0]        base_index;
   } window_result_type;

   // One pending input item; hold_for_drain makes the sender wait until
   // every outstanding result has arrived before offering it.
   typedef struct {
      logic [rwt_pkg::INDEX_W-1:0] index;
      bit                          hold_for_drain;
   } mark_item_type;

   localparam int PHASES         = 8;
   localparam int MARKS_PER_PHASE = 165;

   // Directed marks, applied from reset with a window size of 64.
   localparam logic [rwt_pkg::INDEX_W-1:0] DIRECTED_MARKS [0:12] = '{
      64'd0,                     // new mark at the base, base moves by one
      64'd0,                     // below the base now
      64'd2,                     // new mark, leaves a hole at 1
      64'd2,                     // already marked
      64'd1,                     // fills the hole, base moves by two
      64'd67,                    // first index beyond the window
      64'd66,                    // last index inside the window
      64'hFFFF_FFFF_FFFF_FFFF,   // wraps to just below the base
      64'h8000_0000_0000_0003,   // offset of exactly 2^63 counts as below
      64'h8000_0000_0000_0002,   // offset of 2^63-1 is beyond the window
      64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555,
      64'd3                      // new mark at the base, base moves on to 4
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [rwt_pkg::INDEX_W-1:0]   req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [rwt_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_we = 1'b0;
   logic [rwt_pkg::WS_W-1:0]      csr_wdata = '0;

   // Predicted state of the window.
   logic [rwt_pkg::INDEX_W-1:0]   win_base  = '0;
   logic [rwt_pkg::WINDOW-1:0]    win_flags = '0;
   logic [rwt_pkg::WS_W-1:0]      win_size  = rwt_pkg::WS_RESET;

   mark_item_type        mark_queue [$];
   window_result_type    expected_results [$];
   mark_item_type        next_mark;
   window_result_type    seen_result;
   window_result_type    want_result;
   int                   fail_count   = 0;
   int                   marks_queued = 0;
   int                   burst_left   = 1;
   int                   gap_left     = 0;
   logic [15:0]          ready_pattern = 16'hFFFF;
   int                   pattern_age  = 0;

   receive_window_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mark one index in the predicted window and work out its result item.
   function automatic window_result_type predict_mark(
         input logic [rwt_pkg::INDEX_W-1:0] mark_index);
      logic [rwt_pkg::INDEX_W-1:0] offset;
      int                          slide;
      logic [rwt_pkg::WS_W-1:0]    shown;
      window_result_type           r;
      r = '0;
      offset = mark_index - win_base;
      if (offset[rwt_pkg::INDEX_W-1]) begin
         r.mark_status = rwt_pkg::STATUS_SETTLED;
      end else if (offset >= rwt_pkg::INDEX_W'(rwt_pkg::WINDOW)) begin
         r.mark_status = rwt_pkg::STATUS_BEYOND;
      end else if (win_flags[offset[rwt_pkg::IDX_W-1:0]]) begin
         r.mark_status = rwt_pkg::STATUS_SETTLED;
      end else begin
         win_flags[offset[rwt_pkg::IDX_W-1:0]] = 1'b1;
         r.mark_status = rwt_pkg::STATUS_NEW;
      end
      // Slide the base past every leading consumed flag.
      slide = 0;
      while (slide < rwt_pkg::WINDOW && win_flags[slide])
         slide++;
      if (slide >= rwt_pkg::WINDOW)
         win_flags = '0;
      else
         win_flags = win_flags >> slide;
      win_base = win_base + rwt_pkg::INDEX_W'(slide);
      shown = (win_size > rwt_pkg::WS_MAX) ? rwt_pkg::WS_MAX : win_size;
      r.pending_mask = (shown >= rwt_pkg::WS_W'(rwt_pkg::MASK_W)) ? '1
                                                                 : ((64'd1 << shown) - 64'd1);
      r.pending_mask = r.pending_mask & ~rwt_pkg::MASK_W'(win_flags);
      r.base_index = win_base;
      r.advance_count = rwt_pkg::ADV_W'(slide);
      return r;
   endfunction

   task automatic push_mark(input logic [rwt_pkg::INDEX_W-1:0] index, input bit hold);
      mark_item_type m;
      m.index = index;
      m.hold_for_drain = hold;
      mark_queue.insert(mark_queue.size(), m);
      marks_queued++;
   endtask

   // Queue one run that marks every index of [run_start, run_start+run_len)
   // in shuffled order, with noise marks mixed in: repeats, indexes far
   // beyond the run, indexes just below it and random ones. A full sweep
   // marks the base last so that the whole run fills at once. A dropped
   // mark leaves a hole that stalls the base.
   task automatic queue_run(inout logic [rwt_pkg::INDEX_W-1:0] run_start, input int run_len,
                            input bit full_sweep, input bit drop_one, input bit hold);
      int                          offs [rwt_pkg::WINDOW];
      int                          k, j, tmp, drop_at;
      logic [rwt_pkg::INDEX_W-1:0] noise;
      for (k = 0; k < run_len; k++)
         offs[k] = k;
      for (k = run_len - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = offs[k];
         offs[k] = offs[j];
         offs[j] = tmp;
      end
      if (full_sweep) begin
         for (k = 0; k < run_len; k++) begin
            if (offs[k] == 0) begin
               offs[k] = offs[run_len-1];
               offs[run_len-1] = 0;
            end
         end
      end
      drop_at = drop_one ? $urandom_range(0, run_len - 1) : -1;
      for (k = 0; k < run_len; k++) begin
         if (k != drop_at) begin
            push_mark(run_start + rwt_pkg::INDEX_W'(offs[k]), hold && k == 0);
         end
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
               0: noise = run_start + rwt_pkg::INDEX_W'(offs[k]);
               1: noise = run_start + rwt_pkg::INDEX_W'(run_len + rwt_pkg::WINDOW +
                                                         $urandom_range(0, 1000));
               2: noise = run_start - rwt_pkg::INDEX_W'(1 + $urandom_range(0, 100));
               3: noise = (run_start + {$urandom(), $urandom()}) | (64'd1 << 62);
               default: noise = {$urandom(), $urandom()};
            endcase
            push_mark(noise, 1'b0);
         end
      end
      run_start = run_start + rwt_pkg::INDEX_W'(run_len);
   endtask

   task automatic wait_until_drained();
      while (mark_queue.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Sender: offers queued items in bursts with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.insert(expected_results.size(), predict_mark(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (mark_queue.size() != 0 &&
                         !(mark_queue[0].hold_for_drain && expected_results.size() != 0)) begin
               next_mark = mark_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_mark.index;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls on a rotating pattern that is reloaded now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_age <= 0) begin
            pattern_age = $urandom_range(50, 300);
            if ($urandom_range(0, 3) == 0)
               ready_pattern = 16'hFFFF;
            else
               ready_pattern = 16'($urandom()) | 16'h0001;
         end
         pattern_age--;
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         rsp_tready <= ready_pattern[0];
      end
   end

   // Result checker: each accepted result is compared with the oldest
   // prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_result = rsp_tdata;
         if (expected_results.size() == 0) begin
            $error("result item with no expectation waiting: %h", rsp_tdata);
            fail_count++;
         end else begin
            want_result = expected_results.pop_front();
            if (seen_result.base_index !== want_result.base_index) begin
               $error("base_index mismatch: expected %h, actual %h",
                      want_result.base_index, seen_result.base_index);
               fail_count++;
            end
            if (seen_result.advance_count !== want_result.advance_count) begin
               $error("advance_count mismatch: expected %0d, actual %0d",
                      want_result.advance_count, seen_result.advance_count);
               fail_count++;
            end
            if (seen_result.pending_mask !== want_result.pending_mask) begin
               $error("pending_mask mismatch: expected %h, actual %h",
                      want_result.pending_mask, seen_result.pending_mask);
               fail_count++;
            end
            if (seen_result.mark_status !== want_result.mark_status) begin
               $error("mark_status mismatch: expected %0d, actual %0d",
                      want_result.mark_status, seen_result.mark_status);
               fail_count++;
            end
         end
      end
   end

   // Stimulus: directed marks, then window-filling runs under each setting.
   initial begin
      logic [rwt_pkg::INDEX_W-1:0] run_start;
      logic [rwt_pkg::WS_W-1:0]    size_plan [PHASES];
      int                          phase, k, phase_first, run_len;
      bit                          last_run;
      size_plan = '{rwt_pkg::WS_RESET, 7'd1, 7'd0, 7'd127, 7'd65, 7'd63, 7'd2,
                    rwt_pkg::WS_MAX};
      size_plan[6] = rwt_pkg::WS_W'($urandom_range(2, 62));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < 13; k++)
         push_mark(DIRECTED_MARKS[k], 1'b0);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_until_drained();
         // Window size is only changed while nothing is in flight.
         if (phase > 0) begin
            @(posedge clock);
            csr_we    <= 1'b1;
            csr_wdata <= size_plan[phase];
            win_size = size_plan[phase];
            @(posedge clock);
            csr_we <= 1'b0;
         end
         run_start = win_base;
         phase_first = marks_queued;
         last_run = 1'b0;
         // The first run of each phase fills the whole window at once.
         queue_run(run_start, rwt_pkg::WINDOW, 1'b1, 1'b0, 1'b0);
         while (!last_run) begin
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(33, rwt_pkg::WINDOW)
                                                  : $urandom_range(1, 32);
            last_run = (marks_queued - phase_first + run_len) >= MARKS_PER_PHASE;
            queue_run(run_start, run_len, $urandom_range(0, 5) == 0,
                      last_run && $urandom_range(0, 1) == 1,
                      $urandom_range(0, 7) == 0);
         end
      end

      wait_until_drained();
      repeat (80) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d result items never arrived", expected_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rwt_pkg.sv
rtl/rwt_cell.sv
rtl/receive_window_tracker.sv
sim/tb_receive_window_tracker.sv
